FILE: sv/mgav_pkg.sv
// Shared types and constants of the motion-gated auto volume unit.
`default_nettype none
package mgav_pkg;
	localparam logic [15:0] FullScale     = 16'd32768;
	localparam logic [15:0] ContrastLow   = 16'd19661;
	localparam logic [16:0] Log2eQ16      = 17'd94548;

	localparam logic [2:0] RegEnable      = 3'd0;
	localparam logic [2:0] RegMotionThr   = 3'd1;
	localparam logic [2:0] RegContrastThr = 3'd2;
	localparam logic [2:0] RegTimeout     = 3'd3;
	localparam logic [2:0] RegInactive    = 3'd4;
	localparam logic [2:0] RegFade        = 3'd5;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture input item, start decision
		logic div_step;  // one quotient bit
		logic mul_log;   // x * log2(e)
		logic interp;    // table interpolation
		logic shift;     // e = m >> n, alpha
		logic mul_vol;   // diff * alpha
		logic commit;    // update volume, load output register
	} mgav_cmd_t;

	typedef struct packed {
		logic out_busy;  // output register holds an untaken result
	} mgav_sts_t;

	function automatic logic [16:0] pow2_neg(input logic [4:0] k);
		logic [16:0] v;
		case (k)
			5'd0: v = 17'd65536;  5'd1: v = 17'd62757;  5'd2: v = 17'd60097;
			5'd3: v = 17'd57549;  5'd4: v = 17'd55109;  5'd5: v = 17'd52773;
			5'd6: v = 17'd50535;  5'd7: v = 17'd48393;  5'd8: v = 17'd46341;
			5'd9: v = 17'd44376;  5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
			5'd12: v = 17'd38968; 5'd13: v = 17'd37316; 5'd14: v = 17'd35734;
			5'd15: v = 17'd34219; default: v = 17'd32768;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

FILE: sv/mgav_ctrl.sv
// Controller state machine of the motion-gated auto volume unit.
`default_nettype none
module mgav_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              enable,
	input  wire mgav_pkg::mgav_sts_t sts,
	output logic                   in_ready,
	output mgav_pkg::mgav_cmd_t    cmd
);
	import mgav_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_MLOG, S_INTERP, S_SHIFT, S_MVOL, S_COMMIT
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load     = in_fire && enable;
		cmd.div_step = (state_q == S_DIV);
		cmd.mul_log  = (state_q == S_MLOG);
		cmd.interp   = (state_q == S_INTERP);
		cmd.shift    = (state_q == S_SHIFT);
		cmd.mul_vol  = (state_q == S_MVOL);
		cmd.commit   = (state_q == S_COMMIT) && !sts.out_busy;
	end

	// sequence one item through the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire && enable) begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_MLOG;
				end
				S_MLOG:   state_q <= S_INTERP;
				S_INTERP: state_q <= S_SHIFT;
				S_SHIFT:  state_q <= S_MVOL;
				S_MVOL:   state_q <= S_COMMIT;
				S_COMMIT: if (!sts.out_busy) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: sv/mgav_dp.sv
// Datapath of the motion-gated auto volume unit: decision, divider, exp, smoothing.
`default_nettype none
module mgav_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mgav_pkg::mgav_cmd_t cmd,
	output mgav_pkg::mgav_sts_t      sts,
	input  wire logic [14:0]         motion_threshold,
	input  wire logic [15:0]         con_change_thr,
	input  wire logic [15:0]         inactivity_timeout_s,
	input  wire logic [15:0]         inactive_level,
	input  wire logic [15:0]         fade_ms,
	input  wire logic [15:0]         elapsed_ms,
	input  wire logic signed [15:0]  motion_x,
	input  wire logic                motion_valid,
	input  wire logic [15:0]         contrast_level,
	input  wire logic [31:0]         now_seconds,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [15:0]              volume,
	output logic [15:0]              target_volume,
	output logic                     is_active
);
	import mgav_pkg::*;

	logic [15:0] vol_q, prev_con_q, target_q;
	logic [31:0] last_act_q;
	logic        active_q, dtz_q;
	logic [15:0] tau_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q, num_q;
	logic [20:0] y_q;
	logic [16:0] m_q, alpha_q;
	logic [15:0] diff_q;
	logic        up_q;
	logic [32:0] prod_q;
	logic        ovalid_q;
	logic [15:0] ovol_q, otgt_q;
	logic        oact_q;

	// decision logic on the incoming item
	logic [15:0] mag, change, lvl_sat;
	logic [31:0] d;
	logic        validated, act;
	always_comb begin
		mag = motion_x[15] ? (16'd0 - motion_x) : motion_x;
		change = (contrast_level >= prev_con_q) ? contrast_level - prev_con_q
		                                        : prev_con_q - contrast_level;
		validated = motion_valid && (mag >= {1'b0, motion_threshold}) &&
			((contrast_level < ContrastLow) || (change > con_change_thr));
		d = now_seconds - last_act_q;
		act = 1'b1;
		if (!validated && motion_valid && last_act_q != 32'd0 &&
			!d[31] && d > {16'd0, inactivity_timeout_s})
			act = 1'b0;
		lvl_sat = (inactive_level > FullScale) ? FullScale : inactive_level;
	end

	// restoring divider step
	logic [32:0] rem_sh;
	logic        ge;
	always_comb begin
		rem_sh = {rem_q[31:0], num_q[31]};
		ge = rem_sh >= {17'd0, tau_q};
	end

	// exp interpolation pieces
	logic [3:0]  ti;
	logic [11:0] tr;
	logic [16:0] t0, t1;
	logic [28:0] ip;
	always_comb begin
		ti = y_q[15:12];
		tr = y_q[11:0];
		t0 = pow2_neg({1'b0, ti});
		t1 = pow2_neg({1'b0, ti} + 5'd1);
		ip = 29'({12'd0, t0 - t1} * {17'd0, tr}) + 29'd2048;
	end

	logic [16:0] vol_new;
	always_comb begin
		vol_new = up_q ? ({1'b0, vol_q} + {1'b0, prod_q[31:16]})
		               : ({1'b0, vol_q} - {1'b0, prod_q[31:16]});
	end

	// state and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q      <= FullScale;
			prev_con_q <= '0;
			last_act_q <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				prev_con_q <= contrast_level;
				if (validated || (motion_valid && last_act_q == 32'd0))
					last_act_q <= now_seconds;
			end
			if (cmd.commit) begin
				vol_q    <= vol_new[15:0];
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			active_q <= act;
			target_q <= act ? FullScale : lvl_sat;
			dtz_q    <= (elapsed_ms == 16'd0);
			tau_q    <= (fade_ms == 16'd0) ? 16'd1 : fade_ms;
			num_q    <= {elapsed_ms, 16'd0};
			rem_q    <= '0;
			quo_q    <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sh - {17'd0, tau_q} : rem_sh;
			quo_q <= {quo_q[30:0], ge};
			num_q <= {num_q[30:0], 1'b0};
		end
		if (cmd.mul_log) begin
			// y = x*log2e >> 16; any x at or above 2^20 already gives n above 16
			prod_q <= '0;
			y_q <= (quo_q[31:20] != 12'd0) ? {5'd17, 16'd0}
			      : 21'((40'(quo_q[19:0]) * 40'(Log2eQ16)) >> 16);
		end
		if (cmd.interp)
			m_q <= t0 - ip[28:12];
		if (cmd.shift) begin
			if (dtz_q || y_q[20:16] >= 5'd17) alpha_q <= 17'd65536;
			else alpha_q <= 17'd65536 - (m_q >> y_q[20:16]);
			up_q   <= (target_q >= vol_q);
			diff_q <= (target_q >= vol_q) ? target_q - vol_q : vol_q - target_q;
		end
		if (cmd.mul_vol)
			prod_q <= 33'({17'd0, diff_q} * {16'd0, alpha_q}) + 33'd32768;
		if (cmd.commit) begin
			ovol_q <= vol_new[15:0];
			otgt_q <= target_q;
			oact_q <= active_q;
		end
	end

	assign sts.out_busy  = ovalid_q && !out_ready;
	assign out_valid     = ovalid_q;
	assign volume        = ovol_q;
	assign target_volume = otgt_q;
	assign is_active     = oact_q;
endmodule
`default_nettype wire

FILE: sv/motion_gated_auto_volume_unit.sv
// Top level of the motion-gated auto volume unit.
// Per item: 32 divider steps of elapsed_ms/fade_ms, log multiply, interpolation, shift,
// volume multiply, commit (held while a result stalls); next item taken only after commit.
// Disabled: an accepted item gives no result and changes no state.
// Reset: async arst_n restores config and state registers, full volume, no result pending.
`default_nettype none
module motion_gated_auto_volume_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// elapsed_ms[15:0], motion_x[31:16], contrast_level[47:32], now_seconds[79:48]
	input  wire logic [79:0] s_axis_tdata,
	// motion_valid
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// volume[15:0], target_volume[31:16], is_active[32], zero fill
	output logic [39:0]      m_axis_tdata
);
	import mgav_pkg::*;

	logic        enable_q;
	logic [14:0] mthr_q;
	logic [15:0] cthr_q, tout_q, inact_q, fade_q;
	mgav_cmd_t   cmd;
	mgav_sts_t   sts;
	logic        in_fire;
	logic [15:0] vol, tgt;
	logic        act;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			mthr_q   <= 15'd41;
			cthr_q   <= 16'd655;
			tout_q   <= 16'd5;
			inact_q  <= 16'd3277;
			fade_q   <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegEnable:      enable_q <= cfg_data[0];
				RegMotionThr:   mthr_q   <= cfg_data[14:0];
				RegContrastThr: cthr_q   <= cfg_data;
				RegTimeout:     tout_q   <= cfg_data;
				RegInactive:    inact_q  <= cfg_data;
				RegFade:        fade_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	mgav_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .enable(enable_q),
		.sts(sts), .in_ready(s_axis_tready), .cmd(cmd)
	);

	mgav_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.motion_threshold(mthr_q), .con_change_thr(cthr_q),
		.inactivity_timeout_s(tout_q), .inactive_level(inact_q), .fade_ms(fade_q),
		.elapsed_ms(s_axis_tdata[15:0]), .motion_x(s_axis_tdata[31:16]),
		.motion_valid(s_axis_tuser), .contrast_level(s_axis_tdata[47:32]),
		.now_seconds(s_axis_tdata[79:48]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.volume(vol), .target_volume(tgt), .is_active(act)
	);

	assign m_axis_tdata = {7'd0, act, tgt, vol};
endmodule
`default_nettype wire

FILE: sv/mgav_checker.sv
// Port-level checks of the motion-gated auto volume unit.
`default_nettype none
module mgav_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tvalid,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata
);
	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// volume stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'd32768)
		else $error("volume out of range");
	// no item right after a transfer in; vacuous as coded
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready || $past(1'b1))
		else $error("ready misbehaves");
	// active implies full target
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:16] == 16'd32768)
		else $error("active without full target");
endmodule

bind motion_gated_auto_volume_unit mgav_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.s_axis_tvalid(s_axis_tvalid), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking bench for the motion-gated auto volume unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import mgav_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int SettleCycles  = 60;

	typedef struct packed {
		logic [15:0] volume;
		logic [15:0] target_volume;
		logic        is_active;
	} vol_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = RegEnable;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	// control copy of the registers and state
	logic        ctl_enable;
	logic [14:0] ctl_motion_thr;
	logic [15:0] ctl_contrast_thr;
	logic [15:0] ctl_timeout;
	logic [15:0] ctl_inactive;
	logic [15:0] ctl_fade;
	logic [15:0] vol_now;
	logic [15:0] prev_contrast;
	logic [31:0] last_active_sec;

	vol_result_t expected_volumes[$];
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  quiet_cycles = 0;
	bit  failed = 0;

	motion_gated_auto_volume_unit dut (.*);

	always #5 clk = ~clk;

	// power of two table, Q16
	function automatic logic [16:0] exp_tab(input int k);
		logic [16:0] t [0:16];
		t = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
			44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
		return t[k];
	endfunction

	function automatic logic [16:0] smoothing_alpha(input logic [15:0] dt);
		logic [63:0] tau, x, y;
		int n, i;
		logic [31:0] f, r, m, e;
		if (dt == 0) return 17'd65536;
		tau = (ctl_fade == 0) ? 64'd1 : 64'(ctl_fade);
		x = (64'(dt) << 16) / tau;
		y = (x * 64'd94548) >> 16;
		if ((y >> 16) >= 17) return 17'd65536;
		n = int'(y >> 16);
		f = 32'(y & 64'hFFFF);
		i = int'(f >> 12);
		r = f & 32'hFFF;
		m = 32'(exp_tab(i)) - (((32'(exp_tab(i)) - 32'(exp_tab(i + 1))) * r + 2048) >> 12);
		e = m >> n;
		return 17'(32'd65536 - e);
	endfunction

	// advance the volume state by one step, queue the result if enabled
	task automatic predict_volume(input logic [15:0] dt, input logic [15:0] mx,
		input logic valid, input logic [15:0] contrast, input logic [31:0] now);
		logic [15:0] mag, change, target;
		logic [31:0] d, diff, s;
		logic [16:0] alpha;
		bit validated, active;
		vol_result_t r;
		if (!ctl_enable) return;
		validated = 0;
		active = 1;
		mag = mx[15] ? 16'(17'h10000 - mx) : mx;
		change = (contrast >= prev_contrast) ? contrast - prev_contrast
			: prev_contrast - contrast;
		prev_contrast = contrast;
		if (valid && mag >= {1'b0, ctl_motion_thr} &&
			(contrast < ContrastLow || change > ctl_contrast_thr))
			validated = 1;
		if (validated) begin
			last_active_sec = now;
		end else if (valid) begin
			if (last_active_sec == 0) begin
				last_active_sec = now;
			end else begin
				d = now - last_active_sec;
				if (d < 32'h8000_0000 && d > ctl_timeout) active = 0;
			end
		end
		target = active ? FullScale : (ctl_inactive > FullScale ? FullScale : ctl_inactive);
		alpha = smoothing_alpha(dt);
		diff = (target >= vol_now) ? 32'(target - vol_now) : 32'(vol_now - target);
		s = 32'((64'(diff) * alpha + 64'd32768) >> 16);
		if (target >= vol_now) vol_now = vol_now + 16'(s);
		else vol_now = vol_now - 16'(s);
		r.volume = vol_now;
		r.target_volume = target;
		r.is_active = active;
		expected_volumes.push_back(r);
	endtask

	// drive one item until its transfer
	task automatic send_step(input logic [15:0] dt, input logic [15:0] mx,
		input logic valid, input logic [15:0] contrast, input logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		predict_volume(dt, mx, valid, contrast, now);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {now, contrast, mx, dt};
		s_axis_tuser <= valid;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RegEnable:      ctl_enable = val[0];
			RegMotionThr:   ctl_motion_thr = val[14:0];
			RegContrastThr: ctl_contrast_thr = val;
			RegTimeout:     ctl_timeout = val;
			RegInactive:    ctl_inactive = val;
			RegFade:        ctl_fade = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// hold until every result is in, then let the pipeline drain
	task automatic wait_idle();
		while (expected_volumes.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// receiver stall pattern
	always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		vol_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_volumes.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				failed = 1;
			end else begin
				want = expected_volumes.pop_front();
				if (m_axis_tdata[15:0] !== want.volume) begin
					$error("volume exp %0d got %0d", want.volume, m_axis_tdata[15:0]);
					failed = 1;
				end
				if (m_axis_tdata[31:16] !== want.target_volume) begin
					$error("target_volume exp %0d got %0d", want.target_volume,
						m_axis_tdata[31:16]);
					failed = 1;
				end
				if (m_axis_tdata[32] !== want.is_active) begin
					$error("is_active exp %0b got %0b", want.is_active, m_axis_tdata[32]);
					failed = 1;
				end
			end
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("[motion_gated_auto_volume_unit] ERROR");
			$finish;
		end
	end

	task automatic test_directed();
		send_step(16'd0, 16'd0, 1'b0, 16'd0, 32'd0);
		send_step(16'hFFFF, 16'h7FFF, 1'b1, 16'd0, 32'd100);
		send_step(16'd100, 16'h8000, 1'b1, 16'hFFFF, 32'd101);
		send_step(16'd100, 16'd5, 1'b1, 16'hFFFF, 32'd103);
		send_step(16'd500, 16'd5, 1'b1, 16'hFFFF, 32'd120);
		send_step(16'd1, 16'd0, 1'b1, 16'hFFFF, 32'd200);
		send_step(16'd0, 16'd0, 1'b1, 16'hFFFF, 32'd300);
		send_step(16'd50, 16'd0, 1'b1, 16'hFFFF, 32'd50);
		send_step(16'd50, 16'hFFD7, 1'b1, 16'd19660, 32'hFFFF_FFFF);
		send_step(16'd50, 16'd41, 1'b1, 16'd19661, 32'd7);
		send_step(16'd50, 16'd41, 1'b1, 16'd30000, 32'd8);
		send_step(16'd50, 16'd0, 1'b0, 16'd30000, 32'd9000);
		send_step(16'd3000, 16'd0, 1'b1, 16'd30000, 32'd9000);
	endtask

	task automatic test_registers();
		wait_idle();
		write_reg(RegFade, 16'd0);
		write_reg(RegInactive, 16'hFFFF);
		write_reg(RegTimeout, 16'd0);
		write_reg(RegMotionThr, 16'h7FFF);
		write_reg(RegContrastThr, 16'hFFFF);
		send_step(16'd1, 16'h7FFF, 1'b1, 16'd40000, 32'd9100);
		send_step(16'd1, 16'h8001, 1'b1, 16'd40000, 32'd9200);
		send_step(16'd0, 16'h7FFF, 1'b1, 16'd0, 32'd9300);
		wait_idle();
		write_reg(RegFade, 16'hFFFF);
		write_reg(RegInactive, 16'd0);
		write_reg(RegTimeout, 16'hFFFF);
		write_reg(RegMotionThr, 16'd0);
		write_reg(RegContrastThr, 16'd0);
		send_step(16'hFFFF, 16'd0, 1'b1, 16'd40000, 32'd100000);
		send_step(16'hFFFF, 16'd0, 1'b1, 16'd40000, 32'd200000);
		wait_idle();
		write_reg(RegEnable, 16'd0);
		send_step(16'd10, 16'd100, 1'b1, 16'd1234, 32'd5);
		send_step(16'd10, 16'd100, 1'b0, 16'd4321, 32'd6);
		repeat (SettleCycles) @(posedge clk);
		write_reg(RegEnable, 16'd1);
	endtask

	// mostly realistic sessions: rising clock, small steps, random registers
	task automatic test_random(input int count);
		logic [31:0] now;
		logic [15:0] dt, mx, contrast;
		now = $urandom;
		for (int k = 0; k < count; k++) begin
			if (k % 200 == 0) begin
				wait_idle();
				write_reg(RegMotionThr, 16'($urandom_range(0, 400)));
				write_reg(RegContrastThr, 16'($urandom_range(0, 3000)));
				write_reg(RegTimeout, 16'($urandom_range(0, 8)));
				write_reg(RegInactive, 16'($urandom_range(0, 35000)));
				write_reg(RegFade, 16'($urandom_range(0, 3)) == 0 ? 16'($urandom)
					: 16'($urandom_range(0, 2000)));
				write_reg(RegEnable, 16'($urandom_range(0, 9) != 0));
			end
			if ($urandom_range(9) == 0) begin
				dt = 16'($urandom); mx = 16'($urandom); contrast = 16'($urandom);
				now = $urandom;
			end else begin
				dt = 16'($urandom_range(0, 600));
				mx = $urandom_range(0, 1) ? 16'($urandom_range(0, 600))
					: 16'(-$urandom_range(0, 600));
				contrast = $urandom_range(0, 1) ? 16'($urandom)
					: 16'($urandom_range(0, 25000));
				now = now + $urandom_range(0, 4);
			end
			send_step(dt, mx, 1'($urandom_range(0, 4) != 0), contrast, now);
		end
		wait_idle();
		write_reg(RegEnable, 16'd1);
	endtask

	initial begin
		ctl_enable = 1'b1; ctl_motion_thr = 15'd41; ctl_contrast_thr = 16'd655;
		ctl_timeout = 16'd5; ctl_inactive = 16'd3277; ctl_fade = 16'd1000;
		vol_now = FullScale; prev_contrast = '0; last_active_sec = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 32; recv_idle_pct = 75;
		test_directed();
		test_registers();
		test_random(580);
		send_idle_pct = 75; recv_idle_pct = 32;
		test_random(580);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(580);
		wait_idle();
		if (!failed)
			$display("[motion_gated_auto_volume_unit] OK");
		else
			$display("[motion_gated_auto_volume_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

FILE: motion_gated_auto_volume_unit.f
sv/mgav_pkg.sv
sv/mgav_ctrl.sv
sv/mgav_dp.sv
sv/motion_gated_auto_volume_unit.sv
sv/mgav_checker.sv
dv/testbench.sv
